### rtl/mdsl_pkg.sv
// ----------------------------------------------------------------------------
// mdsl_pkg
// Shared constants and register codes for the motor duty slew limiter.
// ----------------------------------------------------------------------------
package mdsl_pkg;

  localparam int DUTY_FRAC_BITS_DEF = 14;
  localparam int COEF_FRAC_BITS     = 12;
  localparam int SLEW_FRAC_BITS     = 30;

  localparam int COEF_W  = 24;
  localparam int SLEW_W  = 24;
  localparam int MIN_W   = 15;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 24;
  localparam int SPEED_W = 24;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  // serial arithmetic unit widths
  localparam int MUL_W = 32;
  localparam int SQ_W  = 52;
  localparam int DEN_W = 25;

  // |a| below this value selects the linear solve (100*|a| < 2^COEF_FRAC_BITS)
  localparam int LIN_LIMIT = (2 ** COEF_FRAC_BITS + 99) / 100;

  localparam logic [COEF_W-1:0] COEF_A_RST = 24'd0;
  localparam logic [COEF_W-1:0] COEF_B_RST = 24'd4096;
  localparam logic [COEF_W-1:0] COEF_C_RST = 24'd0;
  localparam logic [SLEW_W-1:0] SLEW_RST   = 24'd1610;
  localparam logic [MIN_W-1:0]  MIN_RST    = 15'd0;

  localparam logic [SPEED_W-2:0] SPEED_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A = 3'd0,
    CFG_COEF_B = 3'd1,
    CFG_COEF_C = 3'd2,
    CFG_SLEW   = 3'd3,
    CFG_MIN    = 3'd4
  } cfg_idx_e;

endpackage

### rtl/mdsl_mul.sv
// ----------------------------------------------------------------------------
// mdsl_mul
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mdsl_mul #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);
  localparam int CW = $clog2(W);

  logic [W-1:0]   a_q;
  logic [2*W:0]   p_q, p_d;
  logic [W:0]     sum;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;

  always_comb begin
    sum = p_q[2*W:W] + (p_q[0] ? {1'b0, a_q} : '0);
    p_d = {1'b0, sum, p_q[W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{(W+1){1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q[2*W-1:0];

endmodule

### rtl/mdsl_div.sv
// ----------------------------------------------------------------------------
// mdsl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mdsl_div #(
  parameter int NW = 42,
  parameter int DW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] n_q;
  logic [DW-1:0] r_q, d_q, r_d;
  logic [DW:0]   sh, diff;
  logic          ge;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  always_comb begin
    sh   = {r_q, n_q[NW-1]};
    diff = sh - {1'b0, d_q};
    ge   = (sh >= {1'b0, d_q});
    r_d  = ge ? diff[DW-1:0] : sh[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[NW-2:0], ge};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

### rtl/mdsl_sqrt.sv
// ----------------------------------------------------------------------------
// mdsl_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module mdsl_sqrt #(
  parameter int W = 52
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   rad_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  localparam int RW = W / 2;
  localparam int CW = $clog2(RW);

  logic [W-1:0]  x_q;
  logic [RW:0]   rem_q, rem_d;
  logic [RW-1:0] root_q;
  logic [RW+2:0] sh, trial, diff;
  logic          ge;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  always_comb begin
    sh    = {rem_q, x_q[W-1:W-2]};
    trial = {1'b0, root_q, 2'b01};
    diff  = sh - trial;
    ge    = (sh >= trial);
    rem_d = ge ? diff[RW:0] : sh[RW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/motor_duty_slew_limiter.sv
// ----------------------------------------------------------------------------
// motor_duty_slew_limiter
// Speed/duty command to slew-limited PWM duty, with speed estimate.
// ----------------------------------------------------------------------------
// One command is processed at a time; in_stall_o stays high from the accepting
// edge until the result is loaded into the output register, and the sequencer
// is then back in idle to take the next command. Each command makes three
// serial multiplier passes, five on the quadratic curve; a speed command off
// the zero-divisor path also runs the divider, and one on the quadratic curve
// runs the square root before it.
// A new command is taken while the previous result still waits on the output;
// a finished result then holds the sequencer, and so the input, until the
// output register frees up.
// ----------------------------------------------------------------------------
module motor_duty_slew_limiter #(
  parameter int DUTY_FRAC_BITS = mdsl_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mdsl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mdsl_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic signed [mdsl_pkg::CMD_W-1:0] command_value_i,
  input  logic [mdsl_pkg::TIME_W-1:0]       time_us_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [DUTY_FRAC_BITS:0]           pwm_level_o,
  output logic                              reverse_line_o,
  output logic signed [1:0]                 direction_o,
  output logic signed [DUTY_FRAC_BITS+1:0]  applied_duty_o,
  output logic                              rate_limited_o,
  output logic                              root_clamped_o,
  output logic                              divide_fault_o,
  output logic signed [mdsl_pkg::SPEED_W-1:0] estimated_speed_o
);
  import mdsl_pkg::*;

  localparam int DW    = DUTY_FRAC_BITS + 2;
  localparam int LW    = DW + 2;
  localparam int ONE   = 1 << DUTY_FRAC_BITS;
  localparam int DMAX  = 2 * ONE + 1;
  localparam int SHIFT = SLEW_FRAC_BITS - DUTY_FRAC_BITS;
  localparam int NUM_W = 28 + DUTY_FRAC_BITS;
  localparam int RW    = SQ_W / 2;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SLEW  = 10'b0000000010,
    ST_BB    = 10'b0000000100,
    ST_AC    = 10'b0000001000,
    ST_ROOT  = 10'b0000010000,
    ST_DIV   = 10'b0000100000,
    ST_LIMIT = 10'b0001000000,
    ST_EA    = 10'b0010000000,
    ST_ET    = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } mdsl_state_e;

  mdsl_state_e state_q, state_d;

  // configuration
  logic [COEF_W-1:0] a_q, b_q, c_q;
  logic [SLEW_W-1:0] slew_q;
  logic [MIN_W-1:0]  min_q;

  // state carried between commands
  logic signed [DW-1:0] prev_duty_q;
  logic [TIME_W-1:0]    prev_time_q;
  logic signed [1:0]    dir_q;

  // per-command working registers
  logic                 mode_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [TIME_W-1:0]    time_q;
  logic [DW-1:0]        delta_q;
  logic signed [DW-1:0] duty_q;
  logic [47:0]          bb_q;
  logic                 qneg_q, clamp_q, fault_q, rate_q;
  logic [DW-1:0]        m_q;
  logic [25:0]          t_q;
  logic signed [SPEED_W-1:0] e_q;

  // output registers
  logic                        out_valid_q;
  logic [DUTY_FRAC_BITS:0]     pwm_q;
  logic                        rev_q;
  logic signed [1:0]           odir_q;
  logic signed [DW-1:0]        oduty_q;
  logic                        orate_q, oclamp_q, ofault_q;
  logic signed [SPEED_W-1:0]   est_q;

  // arithmetic units
  logic               mul_start, div_start, sq_start;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_prod;
  logic               mul_done, div_done, sq_done;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  logic [SQ_W-1:0]    sq_rad;
  logic [RW-1:0]      sq_root;

  mdsl_mul #(.W(MUL_W)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  mdsl_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  mdsl_sqrt #(.W(SQ_W)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
    .done_o(sq_done), .root_o(sq_root)
  );

  // operand preparation
  logic [COEF_W-1:0]    s_mag, a_mag, b_mag;
  logic signed [25:0]   sc;
  logic [24:0]          sc_mag;
  logic                 lin;
  logic [63:0]          step;
  logic [DW-1:0]        delta_d;
  logic signed [31:0]   cmd32;
  logic signed [DW-1:0] direct_duty;
  logic signed [SQ_W-1:0] disc;
  logic                 ac_neg;
  logic signed [27:0]   rb;
  logic [26:0]          rb_mag;
  logic [31:0]          lo32;
  logic [DW-1:0]        lo, dmag;
  logic signed [DW-1:0] solved_duty;

  always_comb begin
    s_mag  = cmd_q[CMD_W-1] ? -cmd_q : cmd_q;
    a_mag  = a_q[COEF_W-1] ? -a_q : a_q;
    b_mag  = b_q[COEF_W-1] ? -b_q : b_q;
    sc     = $signed({2'b00, s_mag}) - $signed({{2{c_q[COEF_W-1]}}, c_q});
    sc_mag = sc[25] ? 25'(-sc) : sc[24:0];
    lin    = (a_mag < COEF_W'(LIN_LIMIT));

    step    = mul_prod >> SHIFT;
    delta_d = (step > 64'(DMAX)) ? DW'(DMAX) : step[DW-1:0];

    cmd32 = 32'($signed(cmd_q));
    if (cmd32 > 32'sd0 + ONE) begin
      direct_duty = DW'(ONE);
    end else if (cmd32 < -ONE) begin
      direct_duty = -DW'(ONE);
    end else begin
      direct_duty = cmd32[DW-1:0];
    end

    ac_neg = a_q[COEF_W-1] ^ ~sc[25];
    if (ac_neg) begin
      disc = $signed(SQ_W'(bb_q)) + $signed(SQ_W'({mul_prod[47:0], 2'b00}));
    end else begin
      disc = $signed(SQ_W'(bb_q)) - $signed(SQ_W'({mul_prod[47:0], 2'b00}));
    end

    rb     = $signed({2'b00, sq_root}) - $signed({{4{b_q[COEF_W-1]}}, b_q});
    rb_mag = rb[27] ? 27'(-rb) : rb[26:0];

    lo32 = (32'(min_q) > 32'(ONE)) ? 32'(ONE) : 32'(min_q);
    lo   = lo32[DW-1:0];
    if (qneg_q) begin
      dmag = lo;
    end else if (div_quot > NUM_W'(ONE)) begin
      dmag = DW'(ONE);
    end else if (div_quot[DW-1:0] < lo) begin
      dmag = lo;
    end else begin
      dmag = div_quot[DW-1:0];
    end
    solved_duty = cmd_q[CMD_W-1] ? -$signed(dmag) : $signed(dmag);
  end

  // slew limit and direction
  logic signed [LW-1:0] prev_x, duty_x, up, dn, l1, l2;
  logic                 f1, f2;
  logic signed [1:0]    new_dir;
  logic signed [DW-1:0] fin_duty;
  logic [DW-1:0]        m_d;

  always_comb begin
    prev_x = {{2{prev_duty_q[DW-1]}}, prev_duty_q};
    duty_x = {{2{duty_q[DW-1]}}, duty_q};
    up     = prev_x + $signed({2'b00, delta_q});
    dn     = prev_x - $signed({2'b00, delta_q});
    f1     = (duty_x > up);
    l1     = f1 ? up : duty_x;
    f2     = (l1 < dn);
    l2     = f2 ? dn : l1;
    if (l2 == '0) begin
      new_dir = 2'sb00;
    end else if (l2[LW-1]) begin
      new_dir = 2'sb11;
    end else begin
      new_dir = 2'sb01;
    end
    if (new_dir != dir_q) begin
      if (new_dir == 2'sb01) begin
        fin_duty = DW'(ONE);
      end else if (new_dir == 2'sb11) begin
        fin_duty = -DW'(ONE);
      end else begin
        fin_duty = '0;
      end
    end else begin
      fin_duty = l2[DW-1:0];
    end
    m_d = fin_duty[DW-1] ? DW'(-fin_duty) : DW'(fin_duty);
  end

  // speed estimate, Horner form with floor division by ONE
  logic [63:0]        ceil_p, floor_p;
  logic signed [63:0] fl_a, fl_t, t64, e64;
  logic [SPEED_W-2:0] e_sat;
  logic signed [SPEED_W-1:0] est_d;

  always_comb begin
    ceil_p  = (mul_prod + 64'(ONE - 1)) >> DUTY_FRAC_BITS;
    floor_p = mul_prod >> DUTY_FRAC_BITS;
    fl_a    = a_q[COEF_W-1] ? -$signed(ceil_p) : $signed(floor_p);
    fl_t    = t_q[25] ? -$signed(ceil_p) : $signed(floor_p);
    t64     = fl_a + 64'($signed(b_q));
    e64     = fl_t + 64'($signed(c_q));
    if (e64 < 0) begin
      e_sat = '0;
    end else if (e64 > 64'(SPEED_MAX)) begin
      e_sat = SPEED_MAX;
    end else begin
      e_sat = e64[SPEED_W-2:0];
    end
    if (dir_q == 2'sb01) begin
      est_d = $signed({1'b0, e_sat});
    end else if (dir_q == 2'sb11) begin
      est_d = -$signed({1'b0, e_sat});
    end else begin
      est_d = '0;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    mul_a     = 32'(a_mag);
    mul_b     = 32'(sc_mag);
    div_num   = NUM_W'(sc_mag) << DUTY_FRAC_BITS;
    div_den   = DEN_W'(b_mag);
    sq_rad    = disc[SQ_W-1] ? '0 : disc;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mul_start = 1'b1;
          mul_a     = time_us_i - prev_time_q;
          mul_b     = 32'(slew_q);
          state_d   = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (mul_done) begin
          if (mode_q || (lin && b_q == '0)) begin
            state_d = ST_LIMIT;
          end else if (lin) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            mul_start = 1'b1;
            mul_a     = 32'(b_mag);
            mul_b     = 32'(b_mag);
            state_d   = ST_BB;
          end
        end
      end
      ST_BB: begin
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = ST_AC;
        end
      end
      ST_AC: begin
        if (mul_done) begin
          sq_start = 1'b1;
          state_d  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          div_start = 1'b1;
          div_num   = NUM_W'(rb_mag) << DUTY_FRAC_BITS;
          div_den   = {a_mag, 1'b0};
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        mul_start = 1'b1;
        mul_b     = 32'(m_d);
        state_d   = ST_EA;
      end
      ST_EA: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = 32'(t64[25] ? 26'(-t64) : t64[25:0]);
          mul_b     = 32'(m_q);
          state_d   = ST_ET;
        end
      end
      ST_ET: begin
        if (mul_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= COEF_A_RST;
      b_q         <= COEF_B_RST;
      c_q         <= COEF_C_RST;
      slew_q      <= SLEW_RST;
      min_q       <= MIN_RST;
      prev_duty_q <= '0;
      prev_time_q <= '0;
      dir_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COEF_A: a_q    <= cfg_wdata_i;
          CFG_COEF_B: b_q    <= cfg_wdata_i;
          CFG_COEF_C: c_q    <= cfg_wdata_i;
          CFG_SLEW:   slew_q <= cfg_wdata_i[SLEW_W-1:0];
          CFG_MIN:    min_q  <= cfg_wdata_i[MIN_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_LIMIT) begin
        prev_duty_q <= fin_duty;
        prev_time_q <= time_q;
        dir_q       <= new_dir;
      end
      if (state_q == ST_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mode_q  <= mode_i;
        cmd_q   <= command_value_i;
        time_q  <= time_us_i;
        clamp_q <= 1'b0;
        fault_q <= 1'b0;
      end
      ST_SLEW: begin
        if (mul_done) begin
          delta_q <= delta_d;
          qneg_q  <= sc[25] ^ b_q[COEF_W-1];
          if (mode_q) begin
            duty_q <= direct_duty;
          end else if (lin && b_q == '0) begin
            fault_q <= 1'b1;
            duty_q  <= cmd_q[CMD_W-1] ? -DW'(ONE) : DW'(ONE);
          end
        end
      end
      ST_BB: begin
        if (mul_done) begin
          bb_q <= mul_prod[47:0];
        end
      end
      ST_AC: begin
        if (mul_done) begin
          clamp_q <= disc[SQ_W-1];
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          qneg_q <= rb[27] ^ a_q[COEF_W-1];
        end
      end
      ST_DIV: begin
        if (div_done) begin
          duty_q <= solved_duty;
        end
      end
      ST_LIMIT: begin
        duty_q <= fin_duty;
        rate_q <= f1 | f2;
        m_q    <= m_d;
      end
      ST_EA: begin
        if (mul_done) begin
          t_q <= t64[25:0];
        end
      end
      ST_ET: begin
        if (mul_done) begin
          e_q <= est_d;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          pwm_q    <= duty_q[DW-1] ? duty_q[DW-2:0] + (DW-1)'(ONE) : duty_q[DW-2:0];
          rev_q    <= duty_q[DW-1];
          odir_q   <= dir_q;
          oduty_q  <= duty_q;
          orate_q  <= rate_q;
          oclamp_q <= clamp_q;
          ofault_q <= fault_q;
          est_q    <= e_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign pwm_level_o       = pwm_q;
  assign reverse_line_o    = rev_q;
  assign direction_o       = odir_q;
  assign applied_duty_o    = oduty_q;
  assign rate_limited_o    = orate_q;
  assign root_clamped_o    = oclamp_q;
  assign divide_fault_o    = ofault_q;
  assign estimated_speed_o = est_q;

  a_dir_matches_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q == 2'sb00) == (prev_duty_q == '0))
    else $error("direction state disagrees with stored duty");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_duty_q <= $signed(DW'(ONE))) && (prev_duty_q >= -$signed(DW'(ONE))))
    else $error("stored duty out of range");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(root_clamped_o && divide_fault_o))
    else $error("root clamp and divide fault both set");

  a_reverse_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reverse_line_o == (direction_o == 2'sb11)))
    else $error("reverse line disagrees with direction");

endmodule
